@@ rtl/core/slipd_pkg.sv @@
`default_nettype none

package slipd_pkg;

    localparam logic [7:0] SYM_END     = 8'hC0;
    localparam logic [7:0] SYM_ESC     = 8'hDB;
    localparam logic [7:0] SYM_ESC_END = 8'hDC;
    localparam logic [7:0] SYM_ESC_ESC = 8'hDD;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW   = 2'd2;

    typedef struct packed {
        logic       operation;
        logic [7:0] byte_in;
        logic [7:0] read_index;
    } slipd_item_t;

    typedef struct packed {
        logic       frame_ready;
        logic [7:0] frame_length;
        logic [7:0] read_byte;
        logic [1:0] error_code;
    } slipd_result_t;

    // per-transaction outcome handed from the framing control to the result stage
    typedef struct packed {
        logic       rd_hit;
        logic       frame_ready;
        logic [7:0] frame_length;
        logic [1:0] error_code;
    } slipd_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/slip_frame_decoder_core.sv @@
`default_nettype none

// channel  | valid         | stall         | payload
// ---------+---------------+---------------+-----------------------
// input    | item_valid    | item_stall    | item   (slipd_item_t)
// output   | result_valid  | result_stall  | result (slipd_result_t)
//
// one transaction per cycle sustained while result_stall is low; a transaction
// passes through the access stage register, then the result register, which
// offers it as a result
// feed writes the frame store in its accept cycle; read addresses the store
// in its accept cycle; its registered read data joins it in the access stage
// reset clears fill length, escape flag and completed length; store untouched
// a stall on the result side backs up through the access stage to item_stall

module slip_frame_decoder_core
    import slipd_pkg::*;
#(
    parameter int MAX_FRAME = 255
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire slipd_item_t   item,
    output logic               result_valid,
    input  wire logic          result_stall,
    output slipd_result_t      result
);

    localparam int AW    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int LEN_W = $clog2(MAX_FRAME + 1);

    slipd_ctl_t    ctl;
    slipd_ctl_t    s1_ctl_reg;
    logic          s1_valid_reg;
    logic          res_valid_reg;
    slipd_result_t res_reg, res_next;
    logic          accept;
    logic          res_free;
    logic          s1_move;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    rdata;

    assign res_free   = !res_valid_reg || !result_stall;
    assign s1_move    = s1_valid_reg && res_free;
    assign item_stall = s1_valid_reg && !res_free;
    assign accept     = item_valid && !item_stall;

    slipd_ctrl #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW),
        .LEN_W     (LEN_W)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .ctl    (ctl),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata)
    );

    slipd_store #(
        .DEPTH (MAX_FRAME),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (accept && ctl.rd_hit),
        .raddr (item.read_index[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept || s1_move)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= ctl;
        end
    end

    always_comb
    begin
        res_next.frame_ready  = s1_ctl_reg.frame_ready;
        res_next.frame_length = s1_ctl_reg.frame_length;
        res_next.error_code   = s1_ctl_reg.error_code;
        res_next.read_byte    = s1_ctl_reg.rd_hit ? rdata : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(s1_ctl_reg))
        else $error("access stage lost a waiting transaction");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && res_valid_reg && result_stall |-> !accept)
        else $error("transaction taken with both stages blocked");

    a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.error_code != ERR_NONE || result.frame_ready)
        |-> result.read_byte == 8'd0)
        else $error("feed result carries read data");

endmodule

`default_nettype wire

@@ rtl/core/slipd_store.sv @@
`default_nettype none

module slipd_store
    import slipd_pkg::*;
#(
    parameter int DEPTH = 255,
    parameter int AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/slipd_ctrl.sv @@
`default_nettype none

module slipd_ctrl
    import slipd_pkg::*;
#(
    parameter int MAX_FRAME = 255,
    parameter int AW        = 8,
    parameter int LEN_W     = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire slipd_item_t   item,
    output slipd_ctl_t         ctl,
    output logic               we,
    output logic [AW-1:0]      waddr,
    output logic [7:0]         wdata
);

    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [LEN_W-1:0] done_len_reg, done_len_next;
    logic             esc_reg, esc_next;
    logic             store_byte;
    logic             feed;

    assign feed = accept && (item.operation == OP_FEED);

    always_comb
    begin
        fill_next       = fill_reg;
        done_len_next   = done_len_reg;
        esc_next        = esc_reg;
        store_byte      = 1'b0;
        wdata           = item.byte_in;
        we              = 1'b0;
        waddr           = fill_reg[AW-1:0];
        ctl.rd_hit      = (item.operation == OP_READ) &&
                          (item.read_index < 8'(done_len_reg));
        ctl.frame_ready = 1'b0;
        ctl.frame_length = 8'd0;
        ctl.error_code  = ERR_NONE;

        if (item.operation == OP_FEED)
        begin
            if (item.byte_in == SYM_END)
            begin
                // leading or empty END leaves everything alone
                if (fill_reg != '0)
                begin
                    ctl.frame_ready  = 1'b1;
                    ctl.frame_length = 8'(fill_reg);
                    done_len_next    = fill_reg;
                    fill_next        = '0;
                    esc_next         = 1'b0;
                end
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
                if (item.byte_in == SYM_ESC_END)
                begin
                    wdata      = SYM_END;
                    store_byte = 1'b1;
                end
                else if (item.byte_in == SYM_ESC_ESC)
                begin
                    wdata      = SYM_ESC;
                    store_byte = 1'b1;
                end
                else
                begin
                    fill_next      = '0;
                    ctl.error_code = ERR_BAD_ESCAPE;
                end
            end
            else if (item.byte_in == SYM_ESC)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                store_byte = 1'b1;
            end

            if (store_byte)
            begin
                if (fill_reg < LEN_W'(MAX_FRAME))
                begin
                    we        = feed;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    fill_next      = '0;
                    esc_next       = 1'b0;
                    ctl.error_code = ERR_OVERFLOW;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            done_len_reg <= '0;
            esc_reg      <= 1'b0;
        end
        else if (feed)
        begin
            fill_reg     <= fill_next;
            done_len_reg <= done_len_next;
            esc_reg      <= esc_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LEN_W'(MAX_FRAME))
        else $error("fill length beyond store depth");

    a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_len_reg <= LEN_W'(MAX_FRAME))
        else $error("completed length beyond store depth");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        feed && ctl.frame_ready |=> fill_reg == '0 && !esc_reg &&
        done_len_reg == LEN_W'($past(ctl.frame_length)))
        else $error("frame completion did not restart the fill");

    a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.error_code != ERR_NONE |-> !we && !ctl.frame_ready)
        else $error("discarded fragment still wrote the store");

endmodule

`default_nettype wire

@@ verif/slip_frame_decoder_core_tb.sv @@
`timescale 1ns / 1ps

module slip_frame_decoder_core_tb;
    import slipd_pkg::*;

    localparam int FRAME_DEPTH = 255;

    logic          clk;
    logic          rst_n;
    logic          item_valid;
    logic          item_stall;
    slipd_item_t   item;
    logic          result_valid;
    logic          result_stall;
    slipd_result_t result;

    bit            quiet;
    int unsigned   items_sent;

    class slip_frame_checker;
        logic [7:0]    frame_mem [FRAME_DEPTH];
        int unsigned   fill_len;
        int unsigned   done_len;
        bit            esc_armed;
        slipd_result_t decoded_q [$];
        int unsigned   mismatches;

        function new();
            fill_len   = 0;
            done_len   = 0;
            esc_armed  = 1'b0;
            mismatches = 0;
        endfunction

        function int unsigned waiting();
            return decoded_q.size();
        endfunction

        // work out what the decoder answers for one accepted transaction
        function void note_item(slipd_item_t it);
            slipd_result_t r;
            logic [7:0]    b;
            r = '0;
            if (it.operation == OP_READ) begin
                if (it.read_index < done_len && it.read_index < FRAME_DEPTH)
                    r.read_byte = frame_mem[it.read_index];
            end
            else begin
                b = it.byte_in;
                if (b == SYM_END) begin
                    // an empty frame leaves the escape flag alone
                    if (fill_len != 0) begin
                        done_len = fill_len;
                        r.frame_ready = 1'b1;
                        r.frame_length = 8'(fill_len);
                        fill_len = 0;
                        esc_armed = 1'b0;
                    end
                end
                else if (esc_armed && b != SYM_ESC_END && b != SYM_ESC_ESC) begin
                    esc_armed = 1'b0;
                    fill_len = 0;
                    r.error_code = ERR_BAD_ESCAPE;
                end
                else if (!esc_armed && b == SYM_ESC) begin
                    esc_armed = 1'b1;
                end
                else begin
                    if (esc_armed)
                        b = (b == SYM_ESC_END) ? SYM_END : SYM_ESC;
                    esc_armed = 1'b0;
                    if (fill_len < FRAME_DEPTH) begin
                        frame_mem[fill_len] = b;
                        fill_len++;
                    end
                    else begin
                        fill_len = 0;
                        r.error_code = ERR_OVERFLOW;
                    end
                end
            end
            decoded_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(slipd_result_t got);
            slipd_result_t want;
            if (decoded_q.size() == 0) begin
                $error("result with nothing outstanding: %h", got);
                mismatches++;
                return;
            end
            want = decoded_q.pop_front();
            compare_field("frame_ready", 8'(want.frame_ready), 8'(got.frame_ready));
            compare_field("frame_length", want.frame_length, got.frame_length);
            compare_field("read_byte", want.read_byte, got.read_byte);
            compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
        endfunction
    endclass

    slip_frame_checker chk;

    slip_frame_decoder_core #(
        .MAX_FRAME    (FRAME_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned draw_wait();
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic send_item(input logic op, input logic [7:0] b, input logic [7:0] idx);
        slipd_item_t it;
        int unsigned gap;
        it.operation  = op;
        it.byte_in    = b;
        it.read_index = idx;
        gap = draw_wait();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        chk.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic feed_byte(input logic [7:0] b);
        send_item(OP_FEED, b, 8'($urandom_range(0, 254)));
    endtask

    task automatic read_at(input logic [7:0] idx);
        send_item(OP_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    // payload byte with its escape sequence where needed
    task automatic put_payload(input logic [7:0] b);
        if (b == SYM_END)
        begin
            feed_byte(SYM_ESC);
            feed_byte(SYM_ESC_END);
        end
        else if (b == SYM_ESC)
        begin
            feed_byte(SYM_ESC);
            feed_byte(SYM_ESC_ESC);
        end
        else
            feed_byte(b);
    endtask

    task automatic bad_escape();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == SYM_END || b == SYM_ESC_END || b == SYM_ESC_ESC);
        feed_byte(SYM_ESC);
        feed_byte(b);
    endtask

    task automatic send_frame(input int unsigned n_bytes);
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0)
            feed_byte(SYM_END);
        for (int unsigned k = 0; k < n_bytes; k++)
        begin
            case ($urandom_range(0, 9))
                0: b = SYM_END;
                1: b = SYM_ESC;
                default: b = 8'($urandom_range(0, 255));
            endcase
            put_payload(b);
            // occasional line noise breaks the fragment
            if ($urandom_range(0, 149) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    bad_escape();
                else
                    feed_byte(SYM_END);
            end
        end
        feed_byte(SYM_END);
    endtask

    task automatic read_back();
        int unsigned top;
        repeat ($urandom_range(0, 4))
        begin
            top = (chk.done_len > 254) ? 254 : chk.done_len;
            if (chk.done_len == 0 || $urandom_range(0, 5) == 0)
                read_at(8'($urandom_range(0, 254)));
            else
                read_at(8'($urandom_range(0, top)));
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(negedge clk);
        while (chk.waiting() != 0) @(negedge clk);
    endtask

    // receiver: draw a stall before every result transaction
    initial
    begin
        int unsigned n;
        result_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            n = draw_wait();
            if (n != 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            chk.check_result(result);
    end

    initial
    begin
        #10_000_000;
        $display("slip_frame_decoder_core_tb: errors");
        $finish;
    end

    initial
    begin
        int unsigned n;
        int unsigned frame_no;
        chk        = new();
        quiet      = 1'b0;
        items_sent = 0;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // nothing completed yet
        read_at(8'd0);
        read_at(8'd254);
        // leading END, then END while an escape is armed with nothing stored
        feed_byte(SYM_END);
        feed_byte(SYM_ESC);
        feed_byte(SYM_END);
        feed_byte(SYM_ESC_END);
        feed_byte(8'h00);
        feed_byte(8'hFF);
        feed_byte(SYM_ESC);
        feed_byte(SYM_ESC_ESC);
        // END with escape armed completes the frame
        feed_byte(SYM_ESC);
        feed_byte(SYM_END);
        read_at(8'd0);
        read_at(8'd3);
        read_at(8'd4);
        read_at(8'd254);
        feed_byte(8'h7E);
        feed_byte(SYM_ESC);
        feed_byte(8'h41);
        feed_byte(SYM_ESC);
        feed_byte(SYM_ESC);
        feed_byte(8'hAA);
        feed_byte(SYM_END);
        read_at(8'd0);
        read_at(8'd1);
        drain();

        frame_no = 0;
        while (items_sent < 875)
        begin
            if (frame_no % 8 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (frame_no == 3)
                n = FRAME_DEPTH;
            else if (frame_no == 7)
                n = FRAME_DEPTH + 1;
            else if ($urandom_range(0, 59) == 0)
                n = $urandom_range(FRAME_DEPTH - 5, FRAME_DEPTH + 3);
            else
                n = $urandom_range(0, 24);
            send_frame(n);
            read_back();
            if (frame_no == 20)
                drain();
            frame_no++;
        end

        drain();
        repeat (10) @(negedge clk);
        if (chk.mismatches == 0 && chk.waiting() == 0)
            $display("slip_frame_decoder_core_tb: clean");
        else
            $display("slip_frame_decoder_core_tb: errors");
        $finish;
    end

endmodule
